// ===== sv/cscan_disk_request_scheduler_unit_defines.svh =====
// Assertion macros for the C-SCAN scheduler checker.
// Needs clk and arst_n in the scope of use.
`ifndef CSCAN_DISK_REQUEST_SCHEDULER_UNIT_DEFINES_SVH
`define CSCAN_DISK_REQUEST_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define CSCAN_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cscan assertion failed");

// next-cycle implication
`define CSCAN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cscan assertion failed");

`endif

// ===== sv/cscan_pkg.sv =====
// Shared types and constants for the C-SCAN request scheduler.
// No dependencies.
package cscan_pkg;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_STEP = 3'b100
	} state_t;

	typedef enum logic [3:0] {
		PH_A    = 4'b0001,
		PH_END  = 4'b0010,
		PH_JUMP = 4'b0100,
		PH_B    = 4'b1000
	} phase_t;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DISK_SIZE  = 2'd0,
		CFG_START_HEAD = 2'd1,
		CFG_SWEEP_LEFT = 2'd2
	} cfg_idx_t;

	localparam int DISK_SIZE_RESET = 200;

	typedef struct packed {
		logic start;
		logic dv;
		logic dir_left;
		logic phase_b;
	} scan_ctl_t;

endpackage

// ===== sv/cscan_disk_request_scheduler_unit.sv =====
// C-SCAN disk request scheduler. Requests load one per cycle while in_stall is low
// into a store of MAX_REQUESTS entries; the beat with is_last closes the batch.
// Scheduling is a series of passes over the store through its single read port:
// each pass reads every stored request and then takes a step, and yields the
// nearest track on the current side. While a batch is scheduled in_stall is high,
// and steps wait while out_stall holds a pending result. Results leave through an
// output register.
module cscan_disk_request_scheduler_unit #(
	parameter int MAX_REQUESTS = 32,
	parameter int TRACK_BITS   = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cscan_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [TRACK_BITS:0]             cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [TRACK_BITS-1:0]           track,
	input  logic                            is_last,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [TRACK_BITS-1:0]           visit_track,
	output logic [TRACK_BITS+1:0]           seek_total,
	output logic                            last_visit,
	output logic                            overflow
);

	localparam int TW = TRACK_BITS;
	localparam int SW = TW + 1;
	localparam int KW = TW + 2;
	localparam int CW = $clog2(MAX_REQUESTS + 1);
	localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

	logic [SW-1:0] n_tracks_q;
	logic [TW-1:0] start_head_q;
	logic          sweep_left_q;

	cscan_pkg::state_t state_q;
	cscan_pkg::phase_t phase_q, phase_nx;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic          dropped_q;
	logic          rd_v_s1;
	logic [TW-1:0] pos_q, head_q, top_q;
	logic          dir_q, ovf_q;
	logic [KW-1:0] seek_q;
	logic [TW-1:0] hold_trk_q;
	logic [KW-1:0] hold_seek_q;

	logic          out_valid_q, out_last_q, out_ovf_q;
	logic [TW-1:0] out_trk_q;
	logic [KW-1:0] out_seek_q;

	logic [TW-1:0] top_c, head_c;
	logic          in_acc, in_range, store, drop;
	logic          rd_issue;
	logic [TW-1:0] rdata;
	logic          found;
	logic [TW-1:0] best;
	cscan_pkg::scan_ctl_t scan_ctl;

	logic          slot_free, step_go;
	logic          emit, go_scan, finish, push, start_scan;
	logic [TW-1:0] end_trk, jump_trk, tgt, emit_trk, gap, add;
	logic [KW-1:0] new_seek;

	// effective last track and clamped head
	always_comb begin
		if (n_tracks_q < SW'(2)) begin
			top_c = TW'(1);
		end else if (n_tracks_q[TW]) begin
			top_c = '1;
		end else begin
			top_c = n_tracks_q[TW-1:0] - TW'(1);
		end
		head_c = (start_head_q > top_c) ? top_c : start_head_q;
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_tracks_q   <= SW'(cscan_pkg::DISK_SIZE_RESET);
			start_head_q <= '0;
			sweep_left_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cscan_pkg::cfg_idx_t'(cfg_index))
				cscan_pkg::CFG_DISK_SIZE:  n_tracks_q   <= cfg_data;
				cscan_pkg::CFG_START_HEAD: start_head_q <= cfg_data[TW-1:0];
				cscan_pkg::CFG_SWEEP_LEFT: sweep_left_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_stall = (state_q != cscan_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign in_range = (track <= top_c);
	assign store    = in_acc && in_range && (cnt_q < CW'(MAX_REQUESTS));
	assign drop     = in_acc && in_range && !(cnt_q < CW'(MAX_REQUESTS));
	assign rd_issue = (state_q == cscan_pkg::ST_SCAN) && (idx_q < cnt_q);

	cscan_req_mem #(
		.DEPTH (MAX_REQUESTS),
		.AW    (AW),
		.DW    (TW)
	) u_mem (
		.clk   (clk),
		.we    (store),
		.waddr (cnt_q[AW-1:0]),
		.wdata (track),
		.re    (rd_issue),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	assign scan_ctl.start    = start_scan;
	assign scan_ctl.dv       = rd_v_s1;
	assign scan_ctl.dir_left = dir_q;
	assign scan_ctl.phase_b  = (phase_q == cscan_pkg::PH_B);

	cscan_scan #(
		.TW (TW)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.rdata  (rdata),
		.pos    (pos_q),
		.head   (head_q),
		.top    (top_q),
		.found  (found),
		.best   (best)
	);

	// step decision
	always_comb begin
		end_trk  = dir_q ? '0 : top_q;
		jump_trk = dir_q ? top_q : '0;
		tgt      = ((phase_q == cscan_pkg::PH_A) || (phase_q == cscan_pkg::PH_B)) ? best : end_trk;
		gap      = (pos_q > tgt) ? (pos_q - tgt) : (tgt - pos_q);
		emit     = 1'b0;
		go_scan  = 1'b0;
		finish   = 1'b0;
		emit_trk = tgt;
		add      = gap;
		phase_nx = phase_q;
		case (phase_q)
			cscan_pkg::PH_A: begin
				if (found) begin
					emit    = 1'b1;
					go_scan = 1'b1;
				end else begin
					phase_nx = cscan_pkg::PH_END;
				end
			end
			cscan_pkg::PH_END: begin
				emit     = (pos_q != end_trk);
				phase_nx = cscan_pkg::PH_JUMP;
			end
			cscan_pkg::PH_JUMP: begin
				emit     = 1'b1;
				emit_trk = jump_trk;
				add      = top_q;
				go_scan  = 1'b1;
				phase_nx = cscan_pkg::PH_B;
			end
			cscan_pkg::PH_B: begin
				if (found) begin
					emit    = 1'b1;
					go_scan = 1'b1;
				end else begin
					finish = 1'b1;
				end
			end
			default: begin
				finish = 1'b1;
			end
		endcase
		new_seek = seek_q + KW'(add);
	end

	assign slot_free  = !out_valid_q || !out_stall;
	assign step_go    = (state_q == cscan_pkg::ST_STEP) && slot_free;
	assign push       = step_go && (emit || finish);
	assign start_scan = (in_acc && is_last) || (step_go && go_scan);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cscan_pkg::ST_IDLE;
			phase_q     <= cscan_pkg::PH_A;
			cnt_q       <= '0;
			idx_q       <= '0;
			dropped_q   <= 1'b0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= rd_issue;
			case (state_q)
				cscan_pkg::ST_IDLE: begin
					if (store) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (drop) begin
						dropped_q <= 1'b1;
					end
					if (in_acc && is_last) begin
						phase_q <= cscan_pkg::PH_A;
						idx_q   <= '0;
						state_q <= cscan_pkg::ST_SCAN;
					end
				end
				cscan_pkg::ST_SCAN: begin
					if (rd_issue) begin
						idx_q <= idx_q + CW'(1);
					end else if (!rd_v_s1) begin
						state_q <= cscan_pkg::ST_STEP;
					end
				end
				cscan_pkg::ST_STEP: begin
					if (step_go) begin
						phase_q <= phase_nx;
						if (finish) begin
							cnt_q     <= '0;
							dropped_q <= 1'b0;
							state_q   <= cscan_pkg::ST_IDLE;
						end else if (go_scan) begin
							idx_q   <= '0;
							state_q <= cscan_pkg::ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= cscan_pkg::ST_IDLE;
				end
			endcase
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && is_last) begin
			head_q      <= head_c;
			top_q       <= top_c;
			dir_q       <= sweep_left_q;
			ovf_q       <= dropped_q || drop;
			pos_q       <= head_c;
			seek_q      <= '0;
			hold_trk_q  <= head_c;
			hold_seek_q <= '0;
		end else if (step_go && emit) begin
			pos_q       <= emit_trk;
			seek_q      <= new_seek;
			hold_trk_q  <= emit_trk;
			hold_seek_q <= new_seek;
		end
		if (push) begin
			out_trk_q  <= hold_trk_q;
			out_seek_q <= hold_seek_q;
			out_last_q <= finish;
			out_ovf_q  <= ovf_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign visit_track = out_trk_q;
	assign seek_total  = out_seek_q;
	assign last_visit  = out_last_q;
	assign overflow    = out_ovf_q;

endmodule

// ===== sv/cscan_req_mem.sv =====
// Request store: one write port, one read port, registered read data.
// No dependencies.
module cscan_req_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/cscan_scan.sv =====
// Scan unit: filters stored tracks against the current sweep window and keeps
// the nearest one. Depends on cscan_pkg.
module cscan_scan #(
	parameter int TW = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cscan_pkg::scan_ctl_t ctl,
	input  logic [TW-1:0]       rdata,
	input  logic [TW-1:0]       pos,
	input  logic [TW-1:0]       head,
	input  logic [TW-1:0]       top,
	output logic                found,
	output logic [TW-1:0]       best
);

	logic          found_q;
	logic [TW-1:0] best_q;
	logic          cand;
	logic          better;
	logic          take;

	always_comb begin
		cand = (ctl.dir_left ? (rdata < pos) : (rdata > pos)) && (rdata <= top) &&
			(!ctl.phase_b || (ctl.dir_left ? (rdata > head) : (rdata < head)));
		better = ctl.dir_left ? (rdata > best_q) : (rdata < best_q);
		take = ctl.dv && !ctl.start && cand && (!found_q || better);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.start) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q <= rdata;
		end
	end

	assign found = found_q;
	assign best  = best_q;

endmodule

// ===== sv/cscan_chk.sv =====
// Port-level checker for the C-SCAN scheduler, bound to the top level.
// Depends on cscan_disk_request_scheduler_unit_defines.svh.
`include "cscan_disk_request_scheduler_unit_defines.svh"

module cscan_chk #(
	parameter int TRACK_BITS = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  is_last,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [TRACK_BITS-1:0] visit_track,
	input logic [TRACK_BITS+1:0] seek_total,
	input logic                  last_visit
);

	// closing beat starts scheduling
	`CSCAN_ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && is_last, in_stall)

	// input reopens only with the final visit loaded
	`CSCAN_ASSERT_NOW(a_reopen_last, $fell(in_stall), out_valid && last_visit)

	// a pending non-final visit means the batch is still running
	`CSCAN_ASSERT_NOW(a_midbatch_busy, out_valid && !last_visit, in_stall)

	`CSCAN_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(visit_track) && $stable(seek_total))

endmodule

bind cscan_disk_request_scheduler_unit cscan_chk #(
	.TRACK_BITS (TRACK_BITS)
) u_cscan_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.is_last     (is_last),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.visit_track (visit_track),
	.seek_total  (seek_total),
	.last_visit  (last_visit)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for cscan_disk_request_scheduler_unit: random-idling
// request/result streams checked against an in-bench C-SCAN order predictor.
// Depends on cscan_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int TRACK_W        = 16;
	localparam int MAX_REQ        = 32;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_AT        = 100;
	localparam int HOLD_CYCLES    = 400;

	typedef struct packed {
		logic [TRACK_W-1:0] visit_track;
		logic [TRACK_W+1:0] seek_total;
		logic               last_visit;
		logic               overflow;
	} visit_t;

	typedef struct packed {
		logic [TRACK_W-1:0] trk;
		logic               last;
	} req_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [cscan_pkg::CFG_IDX_W-1:0] cfg_index = cscan_pkg::CFG_DISK_SIZE;
	logic [TRACK_W:0]                cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic [TRACK_W-1:0]              track = '0;
	logic                            is_last = 1'b0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [TRACK_W-1:0]              visit_track;
	logic [TRACK_W+1:0]              seek_total;
	logic                            last_visit;
	logic                            overflow;

	// predictor state
	logic [TRACK_W:0]   n_tracks_r = 17'd200;
	logic [TRACK_W-1:0] start_head_r = '0;
	logic               sweep_left_r = 1'b0;
	logic [TRACK_W-1:0] req_tracks [MAX_REQ];
	int                 req_count = 0;
	logic               req_dropped = 1'b0;
	int                 arm_pos;
	int                 arm_travel;
	visit_t             route [$];

	visit_t visits_due [$];
	req_t   req_backlog [$];
	int     n_queued = 0;
	int     n_taken = 0;
	int     n_results = 0;
	int     n_fail = 0;
	int     send_idle_pct = 34;
	int     recv_idle_pct = 47;
	int     hold_left = 0;
	bit     hold_done = 1'b0;
	int     quiet = 0;
	logic [TRACK_W-1:0] prev_pick = '0;

	cscan_disk_request_scheduler_unit #(
		.MAX_REQUESTS(MAX_REQ),
		.TRACK_BITS(TRACK_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.track(track),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.visit_track(visit_track),
		.seek_total(seek_total),
		.last_visit(last_visit),
		.overflow(overflow)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int eff_size();
		if (n_tracks_r < 2) return 2;
		if (n_tracks_r > 65536) return 65536;
		return int'(n_tracks_r);
	endfunction

	function automatic void move_to(int t);
		visit_t v;
		arm_travel += (t > arm_pos) ? t - arm_pos : arm_pos - t;
		arm_pos = t;
		v.visit_track = TRACK_W'(t);
		v.seek_total = (TRACK_W+2)'(arm_travel);
		v.last_visit = 1'b0;
		v.overflow = req_dropped;
		route = {route, v};
	endfunction

	// full C-SCAN service order for the stored batch
	function automatic void cscan_order();
		int srt [MAX_REQ];
		int ns, top, head, t, i, j, k;
		visit_t v;
		ns = 0;
		top = eff_size() - 1;
		head = int'(start_head_r);
		if (head > top) head = top;
		for (i = 0; i < req_count; i++) begin
			t = int'(req_tracks[i]);
			if (t > top || t == head) continue;
			j = 0;
			while (j < ns && srt[j] < t) j++;
			if (j < ns && srt[j] == t) continue;
			for (k = ns; k > j; k--) srt[k] = srt[k - 1];
			srt[j] = t;
			ns++;
		end
		route.delete();
		arm_pos = head;
		arm_travel = 0;
		move_to(head);
		if (sweep_left_r) begin
			for (i = ns - 1; i >= 0; i--) if (srt[i] < head) move_to(srt[i]);
			if (arm_pos != 0) move_to(0);
			move_to(top);
			for (i = ns - 1; i >= 0; i--) if (srt[i] > head && srt[i] != top) move_to(srt[i]);
		end else begin
			for (i = 0; i < ns; i++) if (srt[i] > head) move_to(srt[i]);
			if (arm_pos != top) move_to(top);
			move_to(0);
			for (i = 0; i < ns; i++) if (srt[i] < head && srt[i] != 0) move_to(srt[i]);
		end
		for (i = 0; i < route.size(); i++) begin
			v = route[i];
			v.last_visit = (i == route.size() - 1);
			visits_due = {visits_due, v};
		end
	endfunction

	function automatic void take_request(logic [TRACK_W-1:0] t, logic last);
		if (int'(t) < eff_size()) begin
			if (req_count < MAX_REQ) begin
				req_tracks[req_count] = t;
				req_count++;
			end else begin
				req_dropped = 1'b1;
			end
		end
		if (last) begin
			cscan_order();
			req_count = 0;
			req_dropped = 1'b0;
		end
	endfunction

	function automatic void add_req(logic [TRACK_W-1:0] t, logic last);
		req_t r;
		r.trk = t;
		r.last = last;
		req_backlog = {req_backlog, r};
		n_queued++;
	endfunction

	function automatic logic [TRACK_W-1:0] pick_track();
		int top, r;
		logic [TRACK_W-1:0] t;
		top = eff_size() - 1;
		r = $urandom_range(99);
		if (r < 6) t = TRACK_W'(top);
		else if (r < 11) t = '0;
		else if (r < 16) t = (int'(start_head_r) > top) ? TRACK_W'(top) : start_head_r;
		else if (r < 22) t = (top == 65535) ? TRACK_W'($urandom_range(65535)) :
			TRACK_W'($urandom_range(65535, top + 1));
		else if (r < 30) t = prev_pick;
		else t = TRACK_W'($urandom_range(top, 0));
		prev_pick = t;
		return t;
	endfunction

	task automatic write_reg(cscan_pkg::cfg_idx_t idx, logic [TRACK_W:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			cscan_pkg::CFG_DISK_SIZE: n_tracks_r = val;
			cscan_pkg::CFG_START_HEAD: start_head_r = val[TRACK_W-1:0];
			cscan_pkg::CFG_SWEEP_LEFT: sweep_left_r = val[0];
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [TRACK_W:0] ds, logic [TRACK_W:0] hd, logic [TRACK_W:0] lf);
		write_reg(cscan_pkg::CFG_DISK_SIZE, ds);
		write_reg(cscan_pkg::CFG_START_HEAD, hd);
		write_reg(cscan_pkg::CFG_SWEEP_LEFT, lf);
	endtask

	task automatic drain();
		do @(posedge clk); while (n_taken != n_queued || visits_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk) begin
		req_t nxt;
		if (arst_n && in_valid && !in_stall) begin
			take_request(track, is_last);
			n_taken++;
		end
		if (arst_n && (!in_valid || !in_stall)) begin
			if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = req_backlog.pop_front();
				in_valid <= 1'b1;
				track <= nxt.trk;
				is_last <= nxt.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor; one long hold-off once enough beats have passed
	always @(posedge clk) begin
		visit_t exp;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (visits_due.size() == 0) begin
				$error("unexpected visit: track %0d seek %0d", visit_track, seek_total);
				n_fail++;
			end else begin
				exp = visits_due.pop_front();
				if (visit_track !== exp.visit_track) begin
					$error("visit_track expected %0d got %0d", exp.visit_track, visit_track);
					n_fail++;
				end
				if (seek_total !== exp.seek_total) begin
					$error("seek_total expected %0d got %0d", exp.seek_total, seek_total);
					n_fail++;
				end
				if (last_visit !== exp.last_visit) begin
					$error("last_visit expected %0d got %0d", exp.last_visit, last_visit);
					n_fail++;
				end
				if (overflow !== exp.overflow) begin
					$error("overflow expected %0d got %0d", exp.overflow, overflow);
					n_fail++;
				end
			end
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (n_results >= HOLD_AT && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet == WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		int ph, len, n, in_range;
		logic [TRACK_W-1:0] t;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: head at 0, sweep up, 200 tracks
		add_req(16'd120, 1'b0);
		add_req(16'd50, 1'b0);
		add_req(16'd50, 1'b0);
		add_req(16'd0, 1'b0);
		add_req(16'd199, 1'b0);
		add_req(16'd230, 1'b0);
		add_req(16'hFFFF, 1'b1);
		add_req(16'hFFFF, 1'b1);
		drain();
		// smallest disk, head clamped to top, sweep down
		set_regs(17'd2, 17'h1FFFF, 17'd1);
		add_req(16'd0, 1'b0);
		add_req(16'd1, 1'b0);
		add_req(16'd1, 1'b1);
		drain();
		// oversized track count acts as full track range
		set_regs(17'h1FFFF, 17'd30000, 17'd0);
		add_req(16'hFFFF, 1'b0);
		add_req(16'd0, 1'b0);
		add_req(16'd30000, 1'b0);
		add_req(16'd12345, 1'b1);
		drain();
		set_regs(17'd200, 17'd100, 17'd1);
		add_req(16'd0, 1'b0);
		add_req(16'd150, 1'b0);
		add_req(16'd100, 1'b0);
		add_req(16'd199, 1'b0);
		add_req(16'd20, 1'b1);
		drain();

		for (ph = 0; ph < 6; ph++) begin
			if (ph < 2) begin
				send_idle_pct = 34;
				recv_idle_pct = 47;
			end else if (ph < 4) begin
				send_idle_pct = 47;
				recv_idle_pct = 34;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (ph)
				0: set_regs(17'd16, 17'd7, 17'd1);
				1: set_regs(17'd65536, (TRACK_W+1)'($urandom_range(65535)), 17'd0);
				2: set_regs(17'd0, 17'd0, 17'd0);
				3: set_regs(17'd1000, 17'd999, 17'd1);
				4: set_regs((TRACK_W+1)'($urandom_range(131071)),
					(TRACK_W+1)'($urandom_range(131071)),
					(TRACK_W+1)'($urandom_range(131071)));
				default: set_regs(17'd64, 17'd63, 17'h1FFFE);
			endcase
			in_range = 0;
			while (in_range < 28) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(44, 36) : $urandom_range(10, 1);
				for (n = 0; n < len; n++) begin
					t = pick_track();
					if (int'(t) < eff_size()) in_range++;
					add_req(t, n == len - 1);
				end
			end
			drain();
		end

		if (n_fail == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
